// ===== sv/ett_pkg.sv =====
// ----------------------------------------------------------------------------
// ett_pkg
// Shared constants, codes and types of the expiring invite table.
// ----------------------------------------------------------------------------
package ett_pkg;

  // Table geometry and field widths
  localparam int TABLE_ENTRIES = 64;
  localparam int TIME_BITS     = 48;
  localparam int NOW_W         = 48;
  localparam int TW            = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int KEY_W         = 64;
  localparam int EXPIRY_W      = 48;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 11;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Stream widths
  localparam int S_DATA_W      = 3 * KEY_W + NOW_W;
  localparam int M_DATA_W      = 16;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(300000);

  // Operation codes
  localparam logic [KIND_W-1:0] K_ISSUE   = 3'd0;
  localparam logic [KIND_W-1:0] K_CONSUME = 3'd1;
  localparam logic [KIND_W-1:0] K_QUERY   = 3'd2;
  localparam logic [KIND_W-1:0] K_SWEEP   = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  world;
    logic [KEY_W-1:0]  invitee;
    logic [KEY_W-1:0]  token;
    logic [TW-1:0]     now;
  } req_t;

  typedef struct packed {
    logic                granted;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] world;
    logic [KEY_W-1:0] invitee;
    logic [KEY_W-1:0] token;
    logic [TW-1:0]    issued;
  } entry_t;

  // Expired when now - issued >= expiry; a negative difference is live
  function automatic logic aged_out(input logic [TW-1:0] issued,
                                    input logic [TW-1:0] now,
                                    input logic [EXPIRY_W-1:0] expiry);
    logic [TW:0] diff;
    diff = {1'b0, now} - {1'b0, issued};
    return !diff[TW] && (EXPIRY_W'(diff[TW-1:0]) >= expiry);
  endfunction

endpackage

// ===== sv/ett_ram.sv =====
// ----------------------------------------------------------------------------
// ett_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ett_engine.sv =====
// ----------------------------------------------------------------------------
// ett_engine
// Scan sequencer: walks every slot of the entry RAM once per item, keeps the
// slot valid bits and the entry count, then commits the item's update.
// ----------------------------------------------------------------------------
module ett_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  ett_pkg::req_t                   req,
  input  logic [ett_pkg::EXPIRY_W-1:0]    expiry,
  output logic                            ready,
  output logic                            res_valid,
  input  logic                            res_take,
  output ett_pkg::res_t                   res
);
  import ett_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);

  logic [1:0]               state;
  req_t                     req_q;
  logic [CNT_W-1:0]         scan_addr;
  logic                     rd_live;
  logic [IDX_W-1:0]         rd_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  // First key match and lowest free slot seen during the scan
  logic             m_found;
  logic [IDX_W-1:0] m_idx;
  logic             m_aged;
  logic             m_tok_eq;
  logic             f_found;
  logic [IDX_W-1:0] f_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_entry;

  logic rd_valid, key_hit, world_hit, rd_aged, scan_drop;
  logic done_fire, done_set, done_drop, done_granted;
  logic [STATUS_W-1:0] done_status;

  ett_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign rd_valid  = rd_live && valid[rd_idx];
  assign world_hit = rd_valid && (rd_entry.world == req_q.world);
  assign key_hit   = world_hit && (rd_entry.invitee == req_q.invitee);
  assign rd_aged   = rd_valid && aged_out(rd_entry.issued, req_q.now, expiry);
  assign scan_drop = (state == ST_SCAN) &&
                     (((req_q.kind == K_SWEEP) && rd_aged) ||
                      ((req_q.kind == K_CLEAR) && world_hit));

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign done_fire = res_valid && res_take;

  // Decide the item's outcome once the scan is complete
  always_comb begin
    done_set     = 1'b0;
    done_drop    = 1'b0;
    done_granted = 1'b0;
    done_status  = STAT_OK;
    ram_we       = 1'b0;
    ram_waddr    = m_idx;
    ram_wdata    = '{world: req_q.world, invitee: req_q.invitee,
                     token: req_q.token, issued: req_q.now};
    case (req_q.kind)
      K_ISSUE: begin
        if (m_found) begin
          ram_we = done_fire;
        end else if (f_found) begin
          ram_we    = done_fire;
          ram_waddr = f_idx;
          done_set  = 1'b1;
        end else begin
          done_status = STAT_FULL;
        end
      end
      K_CONSUME: begin
        if (!m_found) begin
          done_status = STAT_NOTFOUND;
        end else if (m_aged) begin
          done_drop   = 1'b1;
          done_status = STAT_EXPIRED;
        end else if (!m_tok_eq) begin
          done_status = STAT_MISMATCH;
        end else begin
          done_drop    = 1'b1;
          done_granted = 1'b1;
        end
      end
      K_QUERY: begin
        if (m_found && !m_aged) begin
          done_granted = 1'b1;
        end else begin
          done_status = STAT_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (done_set) begin
      count_next = count + CNT_W'(1);
    end else if (done_drop) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign res = '{granted: done_granted, status: done_status, count: count_next};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_live   <= 1'b0;
      scan_addr <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            scan_addr <= '0;
            rd_live   <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_live <= (scan_addr != LAST);
          if (scan_addr != LAST) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end else if (!rd_live) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item hold and scan bookkeeping
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr[IDX_W-1:0];
    if (start && ready) begin
      req_q   <= req;
      m_found <= 1'b0;
      f_found <= 1'b0;
    end else if (state == ST_SCAN && rd_live) begin
      if (key_hit && !m_found) begin
        m_found  <= 1'b1;
        m_idx    <= rd_idx;
        m_aged   <= rd_aged;
        m_tok_eq <= (rd_entry.token == req_q.token);
      end
      if (!valid[rd_idx] && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= rd_idx;
      end
    end
  end

  // Valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (scan_drop) begin
        valid[rd_idx] <= 1'b0;
        count         <= count - CNT_W'(1);
      end
      if (done_fire) begin
        if (done_set) begin
          valid[f_idx] <= 1'b1;
        end
        if (done_drop) begin
          valid[m_idx] <= 1'b0;
        end
        count <= count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid)))
    else $error("entry count differs from valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LAST)
    else $error("entry count above table size");

  a_write_at_commit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_DONE) && res_take)
    else $error("entry write outside commit");

  a_scan_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (scan_addr == LAST) && !rd_live)
    else $error("commit before scan finished");
`endif

endmodule

// ===== sv/expiring_token_invite_table.sv =====
// ----------------------------------------------------------------------------
// expiring_token_invite_table
// Each accepted item is scanned over every slot of the entry RAM before its
// result is registered onto m_tdata. A new item is accepted only once the
// previous result has been taken; the scan reads one slot of the RAM per cycle.
// Reset clears all slot valid bits, the entry count and the output valid flag,
// and sets expiry_ticks to 300000; no clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
module expiring_token_invite_table (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: expiry_ticks
  input  logic                           cfg_we,
  input  logic [ett_pkg::EXPIRY_W-1:0]   cfg_wdata,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // world_key[63:0], invitee_id[127:64], token[191:128], now_ticks[239:192]
  input  logic [ett_pkg::S_DATA_W-1:0]   s_tdata,
  // kind[2:0]
  input  logic [ett_pkg::KIND_W-1:0]     s_tuser,
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // granted[0], status[3:1], entry_count[14:4], zero pad[15]
  output logic [ett_pkg::M_DATA_W-1:0]   m_tdata
);
  import ett_pkg::*;

  logic [EXPIRY_W-1:0] expiry;
  req_t                req;
  res_t                res;
  logic                eng_ready;
  logic                res_valid;
  logic                out_free;
  logic                res_take;

  // Expiry register: the user must write it only while the table is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= EXPIRY_RESET;
    end else if (cfg_we) begin
      expiry <= cfg_wdata;
    end
  end

  // Unpack the input item; keep only the low time bits of now_ticks
  assign req = '{kind:    s_tuser,
                 world:   s_tdata[0 +: KEY_W],
                 invitee: s_tdata[KEY_W +: KEY_W],
                 token:   s_tdata[2*KEY_W +: KEY_W],
                 now:     s_tdata[3*KEY_W +: TW]};

  assign s_tready = eng_ready;

  ett_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid),
    .req       (req),
    .expiry    (expiry),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: take a result when the slot is empty or being drained
  assign out_free = !m_tvalid || m_tready;
  assign res_take = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {1'b0, COUNT_OUT_W'(res.count), res.status, res.granted};
    end
  end

endmodule

// ===== tb/expiring_token_invite_table_test.sv =====
// ----------------------------------------------------------------------------
// expiring_token_invite_table_test
// Self-checking bench for the expiring invite table. A short table of
// directed items covers the empty table, the widest keys and times, the
// inclusive expiry bound, a refreshed token and the spare operation codes.
// Random items over several expiry settings follow, drawn from small key
// pools so that issued invites are often consumed, queried or aged out.
// Results are checked against scripted values or a behavioural table copy.
// ----------------------------------------------------------------------------
module expiring_token_invite_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ett_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int TIMEOUT_NS      = 20_000_000;
  localparam int HOLD_OFF_CYCLES = 1000;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 2 * (TABLE_ENTRIES + 4);
  localparam int NUM_PHASES      = 7;
  localparam int WORLD_POOL      = 4;
  localparam int GUEST_POOL      = 12;
  localparam int FILL_ITEMS      = TABLE_ENTRIES + 6;

  // Operation codes the block treats as no-ops
  localparam logic [KIND_W-1:0] K_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI  = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX  = '1;
  localparam logic [NOW_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  world;
    logic [KEY_W-1:0]  invitee;
    logic [KEY_W-1:0]  token;
    logic [NOW_W-1:0]  now;
  } invite_op_t;

  typedef struct packed {
    logic                   granted;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
  } outcome_t;

  typedef struct {
    invite_op_t op;
    bit         typed;
    outcome_t   res;
  } script_row_t;

  // --------------------------------------------------------------------------
  // Block ports
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [EXPIRY_W-1:0]   cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // world_key[63:0], invitee_id[127:64], token[191:128], now_ticks[239:192]
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  // kind[2:0]
  logic [KIND_W-1:0]     s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // granted[0], status[3:1], entry_count[14:4], zero pad[15]
  logic [M_DATA_W-1:0]   m_tdata;

  expiring_token_invite_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioural copy of the invite table
  // --------------------------------------------------------------------------
  bit                  tbl_live   [TABLE_ENTRIES];
  logic [KEY_W-1:0]    tbl_world  [TABLE_ENTRIES];
  logic [KEY_W-1:0]    tbl_guest  [TABLE_ENTRIES];
  logic [KEY_W-1:0]    tbl_token  [TABLE_ENTRIES];
  logic [TW-1:0]       tbl_issued [TABLE_ENTRIES];
  int                  tbl_count;
  logic [EXPIRY_W-1:0] lifetime;

  // Results still owed by the block, oldest first
  outcome_t            owed_q[$];

  // Shared between the sender, the receiver and the sequencer
  int                  snd_idle_pct;
  int                  rcv_idle_pct;
  int                  hold_req;
  int                  fail_count;
  int                  n_items;
  int                  n_results;
  int                  n_granted;
  int                  n_full;
  int                  n_expired;
  int                  n_mismatch;

  // Random stimulus state
  logic [KEY_W-1:0]    world_pool [WORLD_POOL];
  logic [KEY_W-1:0]    guest_pool [GUEST_POOL];
  logic [NOW_W-1:0]    clock_now;
  int                  step_lim;
  script_row_t         script_q[$];

  // An entry is stale once now - issued reaches the lifetime; a time
  // earlier than the issue tick keeps it live
  function automatic bit has_lapsed(logic [TW-1:0] issued, logic [TW-1:0] now);
    if (now < issued) return 1'b0;
    return EXPIRY_W'(now - issued) >= lifetime;
  endfunction

  function automatic int find_entry(logic [KEY_W-1:0] world, logic [KEY_W-1:0] guest);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_live[i] && tbl_world[i] == world && tbl_guest[i] == guest) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int i);
    tbl_live[i] = 1'b0;
    tbl_count--;
  endfunction

  // Apply one operation to the table copy and return the result it owes
  function automatic outcome_t apply_op(invite_op_t op);
    outcome_t r;
    int       s;
    int       i;
    r         = '0;
    r.granted = 1'b0;
    r.status  = STAT_OK;
    s         = find_entry(op.world, op.invitee);
    case (op.kind)
      K_ISSUE: begin
        if (s < 0) begin
          // new invite takes the lowest free slot
          for (i = 0; i < TABLE_ENTRIES && s < 0; i++)
            if (!tbl_live[i]) s = i;
          if (s < 0) begin
            r.status = STAT_FULL;
          end else begin
            tbl_live[s]  = 1'b1;
            tbl_world[s] = op.world;
            tbl_guest[s] = op.invitee;
            tbl_count++;
          end
        end
        if (r.status == STAT_OK) begin
          tbl_token[s]  = op.token;
          tbl_issued[s] = op.now;
        end
      end
      K_CONSUME: begin
        if (s < 0) begin
          r.status = STAT_NOTFOUND;
        end else if (has_lapsed(tbl_issued[s], op.now)) begin
          drop_entry(s);
          r.status = STAT_EXPIRED;
        end else if (tbl_token[s] != op.token) begin
          r.status = STAT_MISMATCH;
        end else begin
          drop_entry(s);
          r.granted = 1'b1;
        end
      end
      K_QUERY: begin
        if (s >= 0 && !has_lapsed(tbl_issued[s], op.now)) r.granted = 1'b1;
        else r.status = STAT_NOTFOUND;
      end
      K_SWEEP: begin
        for (i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_live[i] && has_lapsed(tbl_issued[i], op.now)) drop_entry(i);
      end
      K_CLEAR: begin
        for (i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_live[i] && tbl_world[i] == op.world) drop_entry(i);
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(tbl_count);
    return r;
  endfunction

  // Draw one random operation. Keys come mostly from small pools so that
  // later items find the invites issued earlier; while filling, every item
  // issues a fresh key so that the table runs out of slots.
  function automatic invite_op_t random_op(bit filling, int fill_idx);
    invite_op_t op;
    int         r;
    int         s;
    r = $urandom_range(0, 99);
    if (filling)     op.kind = K_ISSUE;
    else if (r < 38) op.kind = K_ISSUE;
    else if (r < 62) op.kind = K_CONSUME;
    else if (r < 80) op.kind = K_QUERY;
    else if (r < 88) op.kind = K_SWEEP;
    else if (r < 94) op.kind = K_CLEAR;
    else begin
      case ($urandom_range(0, 2))
        0:       op.kind = K_SPARE_LO;
        1:       op.kind = K_SPARE_MID;
        default: op.kind = K_SPARE_HI;
      endcase
    end

    if ($urandom_range(0, 99) < 3) op.world = {$urandom, $urandom};
    else op.world = world_pool[$urandom_range(0, WORLD_POOL - 1)];
    if ($urandom_range(0, 99) < 3) op.invitee = {$urandom, $urandom};
    else op.invitee = guest_pool[$urandom_range(0, GUEST_POOL - 1)];
    if (filling) begin
      op.world   = world_pool[fill_idx % WORLD_POOL];
      op.invitee = {32'h0F11_C0DE, 32'(fill_idx)};
    end

    // present the stored token on most consumes of a known invite
    s        = find_entry(op.world, op.invitee);
    op.token = {$urandom, $urandom};
    if (op.kind == K_CONSUME && s >= 0 && $urandom_range(0, 99) < 70)
      op.token = tbl_token[s];

    // advance the time base; now and then jump, step back or land on the
    // expiry bound of the addressed invite
    r = $urandom_range(0, 99);
    if (r < 2) begin
      clock_now = NOW_W'({$urandom, $urandom});
      op.now    = clock_now;
    end else if (r < 9 && s >= 0) begin
      op.now = tbl_issued[s] + lifetime - NOW_W'($urandom_range(0, 1));
    end else if (r < 14) begin
      op.now = clock_now - NOW_W'($urandom_range(0, step_lim));
    end else begin
      clock_now = clock_now + NOW_W'($urandom_range(0, step_lim));
      op.now    = clock_now;
    end
    return op;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, hold it until the block takes it, then log what it owes.
  // Valid stays high when the next item follows straight on.
  task automatic push_item(invite_op_t op, bit typed, outcome_t typed_res);
    outcome_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {op.now, op.token, op.invitee, op.world};
    s_tuser  <= op.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_op(op);
    owed_q.push_back(typed ? typed_res : predicted);
    n_items++;
  endtask

  // Stop offering and wait for every owed result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
  endtask

  // Write the lifetime register; only called with the block idle
  task automatic write_lifetime(logic [EXPIRY_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lifetime  = v;
    step_lim  = (lifetime > 48'd8_000_000) ? 1_000_000 : int'(lifetime / 8) + 2;
  endtask

  task automatic add_row(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] world,
                         logic [KEY_W-1:0] guest, logic [KEY_W-1:0] token,
                         logic [NOW_W-1:0] now, bit typed, bit granted,
                         logic [STATUS_W-1:0] status, int count);
    script_row_t row;
    row.op.kind       = kind;
    row.op.world      = world;
    row.op.invitee    = guest;
    row.op.token      = token;
    row.op.now        = now;
    row.typed         = typed;
    row.res.granted   = granted;
    row.res.status    = status;
    row.res.count     = COUNT_OUT_W'(count);
    script_q.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random back-pressure, a long hold-off on request, and the
  // check of every result item against the oldest owed one
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int       hold;
    outcome_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        n_results++;
        if (owed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %h arrived with nothing owed", m_tdata);
        end else begin
          want = owed_q.pop_front();
          if (m_tdata[0] !== want.granted || m_tdata[3:1] !== want.status ||
              m_tdata[14:4] !== want.count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("result %0d: expected granted %0d status %0d count %0d, got %0d %0d %0d",
                       n_results, want.granted, want.status, want.count,
                       m_tdata[0], m_tdata[3:1], m_tdata[14:4]);
          end
        end
        if (m_tdata[0] === 1'b1)             n_granted++;
        if (m_tdata[3:1] === STAT_FULL)      n_full++;
        if (m_tdata[3:1] === STAT_EXPIRED)   n_expired++;
        if (m_tdata[3:1] === STAT_MISMATCH)  n_mismatch++;
      end
      // pick up a hold-off request and count it down here
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results still owed", owed_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [EXPIRY_W-1:0] phase_life  [NUM_PHASES];
    int                  phase_items [NUM_PHASES];
    outcome_t            none;
    int                  ph;
    int                  k;
    int                  n_directed;

    none         = '0;
    fail_count   = 0;
    n_items      = 0;
    n_results    = 0;
    n_granted    = 0;
    n_full       = 0;
    n_expired    = 0;
    n_mismatch   = 0;
    hold_req     = 0;
    snd_idle_pct = 32;
    rcv_idle_pct = 84;

    // reset state of the table copy
    for (k = 0; k < TABLE_ENTRIES; k++) tbl_live[k] = 1'b0;
    tbl_count = 0;
    lifetime  = EXPIRY_RESET;
    step_lim  = int'(lifetime / 8) + 2;
    clock_now = '0;

    world_pool[0] = '0;
    world_pool[1] = KEY_MAX;
    world_pool[2] = {$urandom, $urandom};
    world_pool[3] = {$urandom, $urandom};
    guest_pool[0] = '0;
    guest_pool[1] = KEY_MAX;
    for (k = 2; k < GUEST_POOL; k++) guest_pool[k] = {$urandom, $urandom};

    // lifetimes per phase: zero, widest, short, tiny, random, reset, mid
    phase_life[0] = '0;                  phase_items[0] = 150;
    phase_life[1] = TICK_MAX;            phase_items[1] = 250;
    phase_life[2] = 48'd1000;            phase_items[2] = 200;
    phase_life[3] = 48'd20;              phase_items[3] = 200;
    phase_life[4] = EXPIRY_W'({$urandom, $urandom}); phase_items[4] = 150;
    phase_life[5] = EXPIRY_RESET;        phase_items[5] = 200;
    phase_life[6] = EXPIRY_W'($urandom_range(0, 1 << 20)); phase_items[6] = 250;

    // Directed script, run at the reset lifetime of 300000 ticks
    // empty table
    add_row(K_QUERY,   '0, '0, '0, '0, 1, 0, STAT_NOTFOUND, 0);
    add_row(K_CONSUME, '0, '0, '0, '0, 1, 0, STAT_NOTFOUND, 0);
    add_row(K_SWEEP,   '0, '0, '0, TICK_MAX, 1, 0, STAT_OK, 0);
    add_row(K_CLEAR,   KEY_MAX, '0, '0, '0, 1, 0, STAT_OK, 0);
    // widest keys, token and time
    add_row(K_ISSUE,   KEY_MAX, KEY_MAX, KEY_MAX, TICK_MAX, 1, 0, STAT_OK, 1);
    add_row(K_QUERY,   KEY_MAX, KEY_MAX, '0, TICK_MAX, 1, 1, STAT_OK, 1);
    add_row(K_CONSUME, KEY_MAX, KEY_MAX, '0, TICK_MAX, 1, 0, STAT_MISMATCH, 1);
    add_row(K_CONSUME, KEY_MAX, KEY_MAX, KEY_MAX, TICK_MAX, 1, 1, STAT_OK, 0);
    // refresh an invite, then probe both sides of the expiry bound
    add_row(K_ISSUE,   '0, '0, '0, 48'd1000, 1, 0, STAT_OK, 1);
    add_row(K_ISSUE,   '0, 64'd1, 64'd5, 48'd2000, 1, 0, STAT_OK, 2);
    add_row(K_ISSUE,   '0, '0, 64'd7, 48'd3000, 1, 0, STAT_OK, 2);
    add_row(K_QUERY,   '0, '0, '0, '0, 1, 1, STAT_OK, 2);
    add_row(K_QUERY,   '0, '0, '0, 48'd303000, 1, 0, STAT_NOTFOUND, 2);
    add_row(K_QUERY,   '0, '0, '0, 48'd302999, 1, 1, STAT_OK, 2);
    add_row(K_CONSUME, '0, '0, '0, 48'd3000, 1, 0, STAT_MISMATCH, 2);
    add_row(K_CONSUME, '0, '0, 64'd7, 48'd303000, 1, 0, STAT_EXPIRED, 1);
    // spare codes leave the table alone
    add_row(K_SPARE_LO,  KEY_MAX, KEY_MAX, KEY_MAX, TICK_MAX, 1, 0, STAT_OK, 1);
    add_row(K_SPARE_MID, '0, 64'd1, 64'd5, '0, 0, 0, STAT_OK, 0);
    add_row(K_SPARE_HI,  KEY_MAX, '0, '0, TICK_MAX, 0, 0, STAT_OK, 0);
    // two invites in one world, a sweep that takes only the invite from tick 2000, a clear
    add_row(K_ISSUE,   64'h5555_AAAA_5555_AAAA, 64'd1, 64'h1234, 48'd5000, 0, 0, STAT_OK, 0);
    add_row(K_ISSUE,   64'h5555_AAAA_5555_AAAA, 64'd2, 64'h5678, 48'd5000, 0, 0, STAT_OK, 0);
    add_row(K_SWEEP,   '0, '0, '0, 48'd302000, 0, 0, STAT_OK, 0);
    add_row(K_QUERY,   '0, 64'd1, '0, 48'd2100, 0, 0, STAT_OK, 0);
    add_row(K_CLEAR,   64'h5555_AAAA_5555_AAAA, '0, '0, '0, 0, 0, STAT_OK, 0);
    add_row(K_QUERY,   64'h5555_AAAA_5555_AAAA, 64'd2, '0, 48'd5000, 0, 0, STAT_OK, 0);
    n_directed = script_q.size();

    // hold reset, then release it once
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script_q[i]) push_item(script_q[i].op, script_q[i].typed, script_q[i].res);

    // Random phases: drain, rewrite the lifetime, then stream items
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_lifetime(phase_life[ph]);
      if (ph < 2) begin
        snd_idle_pct = 32;
        rcv_idle_pct = 84;
      end else if (ph < 4) begin
        snd_idle_pct = 84;
        rcv_idle_pct = 32;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // block the result side for a long stretch while the table fills
      if (ph == 1) hold_req = HOLD_OFF_CYCLES;
      for (k = 0; k < phase_items[ph]; k++)
        push_item(random_op(ph == 1 && k < FILL_ITEMS, k), 1'b0, none);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d directed) through %0d lifetime settings, %0d results back",
             n_items, n_directed, NUM_PHASES + 1, n_results);
    $display("Seen: %0d granted, %0d refused on a full table, %0d aged out, %0d wrong tokens",
             n_granted, n_full, n_expired, n_mismatch);
    if (fail_count == 0 && owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results still owed", fail_count, owed_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
